// File: design/tis_pkg.sv
// Package for the temporal interval splitter: request and result types,
// register map and sizing constants. Used by tis_step and the top level.
`default_nettype none

package tis_pkg;

    localparam int TAG_W      = 16;
    localparam int GROUP_W    = 32;
    localparam int TIME_W     = 64;
    localparam int RES_MAX    = 3;
    localparam int CNT_W      = $clog2(RES_MAX + 1);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam int TAG_BITS_DEF   = 16;
    localparam int GROUP_BITS_DEF = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ALIGN_MODE = 1'b0;

    typedef struct packed {
        logic               end_of_stream;
        logic [TAG_W-1:0]   tuple_tag;
        logic [GROUP_W-1:0] group_id;
        logic [TIME_W-1:0]  valid_lo;
        logic [TIME_W-1:0]  valid_hi;
        logic               split_present;
        logic [TIME_W-1:0]  split_point;
        logic [TIME_W-1:0]  overlap_end;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]   source_tag;
        logic [GROUP_W-1:0] out_group;
        logic [TIME_W-1:0]  new_lo;
        logic [TIME_W-1:0]  new_hi;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_out_item [RES_MAX-1:0] items;
        logic [CNT_W-1:0]        count;
    } t_res_set;

endpackage

`default_nettype wire

// File: design/tis_step.sv
// Sweep-line state and result generation for one request per cycle while i_fire is high.
// Depends on tis_pkg; results are combinational, state updates on i_fire.
`default_nettype none

module tis_step #(
    parameter int TAG_BITS   = tis_pkg::TAG_BITS_DEF,
    parameter int GROUP_BITS = tis_pkg::GROUP_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_align_mode,
    input  wire tis_pkg::t_in_item i_item,
    output tis_pkg::t_res_set      o_res
);

    localparam int TW = (TAG_BITS < tis_pkg::TAG_W) ? TAG_BITS : tis_pkg::TAG_W;
    localparam int GW = (GROUP_BITS < tis_pkg::GROUP_W) ? GROUP_BITS : tis_pkg::GROUP_W;
    localparam int TMW = tis_pkg::TIME_W;

    logic           r_started;
    logic [GW-1:0]  r_prev_group;
    logic [TW-1:0]  r_prev_tag;
    logic [TMW-1:0] r_prev_hi;
    logic [TMW-1:0] r_sweep;
    logic           r_have_last;
    logic [TMW-1:0] r_last_lo;
    logic [TMW-1:0] r_last_hi;
    logic [GW-1:0]  r_last_group;

    logic           n_started;
    logic [GW-1:0]  n_prev_group;
    logic [TW-1:0]  n_prev_tag;
    logic [TMW-1:0] n_prev_hi;
    logic [TMW-1:0] n_sweep;
    logic           n_have_last;
    logic [TMW-1:0] n_last_lo;
    logic [TMW-1:0] n_last_hi;
    logic [GW-1:0]  n_last_group;

    logic [TW-1:0]  tag;
    logic [GW-1:0]  grp;
    logic           eos;
    logic           p1_ok;
    logic [TMW-1:0] p1;
    logic [TMW-1:0] p2;
    logic           new_grp;
    logic           close_v;
    logic           gap_v;
    logic           ov_v;
    logic           repeat_hit;
    logic [TMW-1:0] sweep0;
    logic [TMW-1:0] sweep1;
    logic [TMW-1:0] sweep2;
    tis_pkg::t_out_item close_r;
    tis_pkg::t_out_item gap_r;
    tis_pkg::t_out_item ov_r;

    always_comb begin
        eos   = i_item.end_of_stream;
        tag   = i_item.tuple_tag[TW-1:0];
        grp   = i_item.group_id[GW-1:0];
        p1_ok = i_item.split_present;
        p1    = i_item.split_point;
        p2    = i_item.overlap_end;

        new_grp = r_started && (grp != r_prev_group);
        close_v = r_started && (eos || new_grp) &&
                  ($signed(r_sweep) < $signed(r_prev_hi));
        sweep0  = (!r_started || new_grp) ? i_item.valid_lo : r_sweep;
        gap_v   = !eos && p1_ok && ($signed(sweep0) < $signed(p1));
        sweep1  = gap_v ? p1 : sweep0;

        // a close or gap emitted by this request can never match the overlap
        repeat_hit = r_have_last && (r_last_lo == p1) && (r_last_hi == p2) &&
                     (r_last_group == grp);
        ov_v   = !eos && i_align_mode && p1_ok && (close_v || gap_v || !repeat_hit);
        sweep2 = (ov_v && ($signed(sweep1) < $signed(p2))) ? p2 : sweep1;

        close_r.source_tag = tis_pkg::TAG_W'(r_prev_tag);
        close_r.out_group  = tis_pkg::GROUP_W'(r_prev_group);
        close_r.new_lo     = r_sweep;
        close_r.new_hi     = r_prev_hi;
        close_r.last       = 1'b0;
        gap_r.source_tag   = tis_pkg::TAG_W'(tag);
        gap_r.out_group    = tis_pkg::GROUP_W'(grp);
        gap_r.new_lo       = sweep0;
        gap_r.new_hi       = p1;
        gap_r.last         = 1'b0;
        ov_r.source_tag    = tis_pkg::TAG_W'(tag);
        ov_r.out_group     = tis_pkg::GROUP_W'(grp);
        ov_r.new_lo        = p1;
        ov_r.new_hi        = p2;
        ov_r.last          = 1'b0;

        // pack the emitted results to the front, in close, gap, overlap order
        o_res.items[0] = close_v ? close_r : (gap_v ? gap_r : ov_r);
        o_res.items[1] = close_v ? (gap_v ? gap_r : ov_r) : ov_r;
        o_res.items[2] = ov_r;
        o_res.count    = tis_pkg::CNT_W'(close_v) + tis_pkg::CNT_W'(gap_v) +
                         tis_pkg::CNT_W'(ov_v);
        for (int i = 0; i < tis_pkg::RES_MAX; i++) begin
            o_res.items[i].last = (tis_pkg::CNT_W'(i + 1) == o_res.count);
        end

        n_started    = r_started;
        n_prev_group = r_prev_group;
        n_prev_tag   = r_prev_tag;
        n_prev_hi    = r_prev_hi;
        n_sweep      = r_sweep;
        n_have_last  = r_have_last;
        n_last_lo    = r_last_lo;
        n_last_hi    = r_last_hi;
        n_last_group = r_last_group;
        if (eos) begin
            n_started   = 1'b0;
            n_have_last = 1'b0;
        end else begin
            n_started    = 1'b1;
            n_sweep      = sweep2;
            n_prev_group = grp;
            n_prev_tag   = tag;
            n_prev_hi    = i_item.valid_hi;
            if (ov_v) begin
                n_have_last  = 1'b1;
                n_last_lo    = p1;
                n_last_hi    = p2;
                n_last_group = grp;
            end else if (gap_v) begin
                n_have_last  = 1'b1;
                n_last_lo    = sweep0;
                n_last_hi    = p1;
                n_last_group = grp;
            end else if (close_v) begin
                n_have_last  = 1'b1;
                n_last_lo    = r_sweep;
                n_last_hi    = r_prev_hi;
                n_last_group = r_prev_group;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_prev_group <= '0;
            r_prev_tag   <= '0;
            r_prev_hi    <= '0;
            r_sweep      <= '0;
            r_have_last  <= 1'b0;
            r_last_lo    <= '0;
            r_last_hi    <= '0;
            r_last_group <= '0;
        end else if (i_fire) begin
            r_started    <= n_started;
            r_prev_group <= n_prev_group;
            r_prev_tag   <= n_prev_tag;
            r_prev_hi    <= n_prev_hi;
            r_sweep      <= n_sweep;
            r_have_last  <= n_have_last;
            r_last_lo    <= n_last_lo;
            r_last_hi    <= n_last_hi;
            r_last_group <= n_last_group;
        end
    end

endmodule

`default_nettype wire

// File: design/temporal_interval_splitter.sv
// Top level of the temporal interval splitter: request register, result
// queue and APB register. Depends on tis_pkg and tis_step.
`default_nettype none

// Sweep-line splitter for temporal align/normalize. Send tuples sorted by
// group and split point, then one end-of-stream request. Each request yields
// zero to three results (close of the previous group, gap, overlap), and the
// last flag marks the final result of a request. Results leave one per cycle,
// while the output is not stalled, from a three-entry queue. An accepted
// request is first registered, and its results are then loaded into the queue.
// A new request is taken while the previous one's results still drain.
// Write align_mode (byte address 0) only while the block is idle.
module temporal_interval_splitter #(
    parameter int TAG_BITS   = tis_pkg::TAG_BITS_DEF,
    parameter int GROUP_BITS = tis_pkg::GROUP_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire tis_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output tis_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [tis_pkg::PADDR_W-1:0]   i_paddr,
    input  wire logic [tis_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [tis_pkg::PDATA_W-1:0]        o_prdata,
    output logic                               o_pready
);

    logic                          r_align_mode;
    logic                          r_iv;
    tis_pkg::t_in_item             r_item;
    tis_pkg::t_out_item [tis_pkg::RES_MAX-1:0] r_buf;
    tis_pkg::t_out_item [tis_pkg::RES_MAX-1:0] n_buf;
    logic [tis_pkg::CNT_W-1:0]     r_cnt;
    logic [tis_pkg::CNT_W-1:0]     n_cnt;
    tis_pkg::t_res_set             res;
    logic                          pop;
    logic                          fire;
    logic                          in_take;

    assign o_pready    = 1'b1;
    assign o_prdata    = (i_paddr[2] == tis_pkg::REG_ALIGN_MODE) ?
                         tis_pkg::PDATA_W'(r_align_mode) : '0;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];
    assign pop         = o_out_valid && !i_out_stall;
    // the queue takes a new set once it is empty or its final entry leaves now
    assign fire        = r_iv && ((r_cnt == '0) ||
                         ((r_cnt == tis_pkg::CNT_W'(1)) && pop));
    assign o_in_stall  = r_iv && !fire;
    assign in_take     = i_in_valid && !o_in_stall;

    tis_step #(
        .TAG_BITS   (TAG_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_align_mode (r_align_mode),
        .i_item       (r_item),
        .o_res        (res)
    );

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (fire) begin
            n_buf = res.items;
            n_cnt = res.count;
        end else if (pop) begin
            // advance the queue by one entry
            for (int i = 0; i < tis_pkg::RES_MAX - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_cnt = r_cnt - tis_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_mode <= 1'b0;
            r_iv         <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && o_pready &&
                (i_paddr[2] == tis_pkg::REG_ALIGN_MODE)) begin
                r_align_mode <= i_pwdata[0];
            end
            if (in_take) begin
                r_iv <= 1'b1;
            end else if (fire) begin
                r_iv <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_data;
        end
        r_buf <= n_buf;
    end

`ifndef SYNTHESIS
    a_take_full_fires : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && r_iv) |-> fire)
        else $error("request taken over a held request that did not issue");

    a_last_marks_tail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_buf[0].last == (r_cnt == tis_pkg::CNT_W'(1))))
        else $error("last flag does not match queue tail");

    a_eos_one_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_item.end_of_stream) |-> (res.count <= tis_pkg::CNT_W'(1)))
        else $error("end of stream produced more than one result");

    a_pop_advances : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !fire) |=> (r_cnt == $past(r_cnt) - tis_pkg::CNT_W'(1)))
        else $error("queue count did not advance on a taken result");
`endif

endmodule

`default_nettype wire

// File: tb/tis_checker.sv
// Checker for the temporal interval splitter: watches the request, result and
// register ports, predicts the split ranges and compares them field by field.
// Depends on tis_pkg for the request and result types.

module tis_checker import tis_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire t_in_item             i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out_item            i_out_data,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [PADDR_W-1:0]   i_paddr,
    input  wire logic [PDATA_W-1:0]   i_pwdata,
    input  wire logic [PDATA_W-1:0]   i_prdata,
    input  wire logic                 i_pready,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic               align_mode;
    logic               started;
    logic [GROUP_W-1:0] prev_group;
    logic [TAG_W-1:0]   prev_tag;
    logic [TIME_W-1:0]  prev_hi;
    logic [TIME_W-1:0]  sweep;
    logic               have_last_out;
    logic [TIME_W-1:0]  last_out_lo;
    logic [TIME_W-1:0]  last_out_hi;
    logic [GROUP_W-1:0] last_out_group;

    t_out_item expected_ranges[$];

    function automatic t_out_item make_range(input logic [TAG_W-1:0] tag,
                                             input logic [GROUP_W-1:0] grp,
                                             input logic [TIME_W-1:0] lo,
                                             input logic [TIME_W-1:0] hi);
        t_out_item r;
        r.source_tag = tag;
        r.out_group  = grp;
        r.new_lo     = lo;
        r.new_hi     = hi;
        r.last       = 1'b0;
        have_last_out  = 1'b1;
        last_out_lo    = lo;
        last_out_hi    = hi;
        last_out_group = grp;
        return r;
    endfunction

    // Advance the sweep line by one request and queue the ranges it yields:
    // close of the previous group, then the gap, then the overlap.
    function automatic void split_interval(input t_in_item req);
        t_out_item res[RES_MAX];
        int        n;
        n = 0;
        if (req.end_of_stream) begin
            if (started && $signed(sweep) < $signed(prev_hi)) begin
                res[n] = make_range(prev_tag, prev_group, sweep, prev_hi);
                n++;
            end
            started       = 1'b0;
            have_last_out = 1'b0;
        end else begin
            if (!started) begin
                started = 1'b1;
                sweep   = req.valid_lo;
            end else if (req.group_id != prev_group) begin
                if ($signed(sweep) < $signed(prev_hi)) begin
                    res[n] = make_range(prev_tag, prev_group, sweep, prev_hi);
                    n++;
                end
                sweep = req.valid_lo;
            end
            if (req.split_present && $signed(sweep) < $signed(req.split_point)) begin
                res[n] = make_range(req.tuple_tag, req.group_id, sweep, req.split_point);
                n++;
                sweep = req.split_point;
            end
            // drop an overlap that repeats the most recent range
            if (align_mode && req.split_present) begin
                if (!have_last_out || last_out_lo != req.split_point ||
                    last_out_hi != req.overlap_end || last_out_group != req.group_id) begin
                    res[n] = make_range(req.tuple_tag, req.group_id,
                                        req.split_point, req.overlap_end);
                    n++;
                    if ($signed(sweep) < $signed(req.overlap_end))
                        sweep = req.overlap_end;
                end
            end
            prev_group = req.group_id;
            prev_tag   = req.tuple_tag;
            prev_hi    = req.valid_hi;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_ranges.push_back(res[k]);
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [TIME_W-1:0] want,
                                          input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        o_checked++;
        if (expected_ranges.size() == 0) begin
            $error("result with none pending: tag %0h group %0h lo %0h hi %0h last %0b",
                   got.source_tag, got.out_group, got.new_lo, got.new_hi, got.last);
            o_fail_count++;
            return;
        end
        want = expected_ranges.pop_front();
        compare_field("source_tag", TIME_W'(want.source_tag), TIME_W'(got.source_tag));
        compare_field("out_group", TIME_W'(want.out_group), TIME_W'(got.out_group));
        compare_field("new_lo", want.new_lo, got.new_lo);
        compare_field("new_hi", want.new_hi, got.new_hi);
        compare_field("last", TIME_W'(want.last), TIME_W'(got.last));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            align_mode     = 1'b0;
            started        = 1'b0;
            prev_group     = '0;
            prev_tag       = '0;
            prev_hi        = '0;
            sweep          = '0;
            have_last_out  = 1'b0;
            last_out_lo    = '0;
            last_out_hi    = '0;
            last_out_group = '0;
            expected_ranges.delete();
            o_fail_count   = 0;
            o_checked      = 0;
        end else begin
            // results leave only after their request has been registered
            if (i_out_valid && !i_out_stall)
                check_result(i_out_data);
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_ALIGN_MODE) begin
                if (i_pwrite) begin
                    align_mode = i_pwdata[0];
                end else if (i_prdata[0] !== align_mode) begin
                    $error("align_mode: expected %0b, got %0b", align_mode, i_prdata[0]);
                    o_fail_count++;
                end
            end
            if (i_in_valid && !i_in_stall)
                split_interval(i_in_data);
        end
        o_pending = expected_ranges.size();
    end

endmodule

// File: tb/tb_temporal_interval_splitter.sv
// Top of the temporal interval splitter testbench: clock, reset, request
// stimulus, result stalls and register writes. Depends on tis_pkg, the block
// and tis_checker, which predicts and compares.

module tb_temporal_interval_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import tis_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 80;
    localparam logic [TIME_W-1:0] T_MIN = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    t_in_item           req_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] o_prdata;
    logic               o_pready;

    int fail_count;
    int pending;
    int checked;
    int requests_sent = 0;
    int eos_sent      = 0;
    int settings_used = 0;
    bit calm_in       = 1'b0;
    bit calm_out      = 1'b0;

    temporal_interval_splitter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (req_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (o_prdata),
        .o_pready    (o_pready)
    );

    tis_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (req_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (o_prdata),
        .i_pready     (o_pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: hold stall for a random count, then take one result.
    initial begin
        int hold;
        forever begin
            if ($urandom_range(0, 47) == 0)
                calm_out = !calm_out;
            hold = calm_out ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(o_out_valid && !out_stall));
        end
    end

    task automatic send_request(input t_in_item req);
        int gap;
        if ($urandom_range(0, 47) == 0)
            calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        do @(posedge clk); while (o_in_stall);
        requests_sent++;
        if (req.end_of_stream)
            eos_sent++;
    endtask

    // Drain every pending result, then let requests with no result finish.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_ALIGN_MODE, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!o_pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_align_mode(input logic mode);
        apb_access(1'b1, PDATA_W'(mode));
        apb_access(1'b0, '0);
        settings_used++;
    endtask

    function automatic t_in_item tuple_req(input logic [TAG_W-1:0] tag,
                                           input logic [GROUP_W-1:0] grp,
                                           input logic [TIME_W-1:0] lo,
                                           input logic [TIME_W-1:0] hi,
                                           input logic present,
                                           input logic [TIME_W-1:0] p1,
                                           input logic [TIME_W-1:0] p2);
        t_in_item r;
        r.end_of_stream = 1'b0;
        r.tuple_tag     = tag;
        r.group_id      = grp;
        r.valid_lo      = lo;
        r.valid_hi      = hi;
        r.split_present = present;
        r.split_point   = p1;
        r.overlap_end   = p2;
        return r;
    endfunction

    // Any request with random content; end_of_stream decided by the caller.
    function automatic t_in_item noise_req(input logic eos);
        t_in_item r;
        r = tuple_req(TAG_W'($urandom), GROUP_W'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom});
        r.end_of_stream = eos;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        logic signed [TIME_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = T_MIN;
            1:       v = T_MAX;
            2, 3:    v = {$urandom, $urandom};
            default: begin
                v = TIME_W'($urandom_range(0, 200)) - 64'd100;
            end
        endcase
        return v;
    endfunction

    // One group of tuples with non-decreasing split points; some pairs repeat.
    task automatic send_group(input logic [GROUP_W-1:0] grp);
        int                count;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] p1;
        logic [TIME_W-1:0] p2;
        count = $urandom_range(1, 5);
        lo = pick_time();
        p1 = ($urandom_range(0, 3) == 0) ? pick_time() : lo - 64'($urandom_range(0, 8));
        p2 = p1;
        repeat (count) begin
            hi = ($urandom_range(0, 5) == 0) ? pick_time() : lo + 64'($urandom_range(0, 120));
            if ($urandom_range(0, 3) != 0) begin
                p1 = p1 + 64'($urandom_range(0, 12));
                p2 = ($urandom_range(0, 7) == 0) ? pick_time()
                                                 : p1 + 64'($urandom_range(0, 24)) - 64'd4;
            end
            send_request(tuple_req(TAG_W'($urandom), grp, lo, hi,
                                   $urandom_range(0, 7) != 0, p1, p2));
            if ($urandom_range(0, 3) == 0)
                lo = pick_time();
        end
    endtask

    task automatic send_stream();
        logic [GROUP_W-1:0] grp;
        int                 groups;
        grp    = ($urandom_range(0, 2) == 0) ? GROUP_W'($urandom)
                                             : GROUP_W'($urandom_range(0, 20));
        groups = $urandom_range(1, 4);
        repeat (groups) begin
            send_group(grp);
            grp = grp + GROUP_W'($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) != 0)
            send_request(noise_req(1'b1));
    endtask

    initial begin
        int start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // normalizer at its reset setting
        send_request(noise_req(1'b1));
        send_request(tuple_req(16'h0000, 32'h0, T_MIN, T_MAX, 1'b1, T_MIN, T_MIN));
        send_request(tuple_req(16'hFFFF, 32'h0, T_MIN, T_MAX, 1'b1, 64'd0, 64'd5));
        send_request(tuple_req(16'h1234, 32'h0, 64'd0, T_MAX, 1'b0, 64'd50, 64'd0));
        send_request(tuple_req(16'h00FF, 32'h0, 64'd0, T_MAX, 1'b1, T_MAX, T_MAX));
        send_request(tuple_req(16'hA5A5, 32'hFFFF_FFFF, 64'(-5), 64'd10, 1'b1, 64'd3, 64'd7));
        send_request(tuple_req(16'h5A5A, 32'h1, 64'(-20), 64'd40, 1'b1, 64'(-20), 64'd0));
        send_request(noise_req(1'b1));
        send_request(noise_req(1'b1));
        settle();

        // aligner: overlap, repeat, reversed, empty, three results at once
        set_align_mode(1'b1);
        send_request(tuple_req(16'h0001, 32'd5, 64'd0, 64'd100, 1'b1, 64'd10, 64'd20));
        send_request(tuple_req(16'h0002, 32'd5, 64'd0, 64'd100, 1'b1, 64'd10, 64'd20));
        send_request(tuple_req(16'h0003, 32'd5, 64'd0, 64'd100, 1'b1, 64'd30, 64'd25));
        send_request(tuple_req(16'h0004, 32'd5, 64'd0, 64'd100, 1'b1, 64'd30, 64'd30));
        send_request(tuple_req(16'h0005, 32'd6, 64'(-100), 64'd50, 1'b1, 64'd40, T_MAX));
        send_request(tuple_req(16'h0006, 32'd6, 64'(-100), 64'd50, 1'b0, 64'd40, T_MAX));
        send_request(noise_req(1'b1));
        send_request(tuple_req(16'h0007, 32'd7, T_MIN, T_MIN, 1'b1, T_MIN, T_MIN));
        send_request(tuple_req(16'h0008, 32'd7, T_MIN, T_MAX, 1'b1, T_MIN, T_MIN));
        send_request(noise_req(1'b1));

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            set_align_mode(phase % 2 == 1);
            start = requests_sent;
            while (requests_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(noise_req($urandom_range(0, 3) == 0));
                else
                    send_stream();
            end
        end
        settle();

        $display("Summary: %0d requests (%0d end-of-stream) under %0d align_mode settings",
                 requests_sent, eos_sent, settings_used);
        $display("Summary: %0d split ranges compared against the sweep-line prediction",
                 checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
